>>> src/gb3_pkg.sv
// ----------------------------------------------------------------------------
// gb3_pkg
// Shared widths, kernel weights and the position record used by the 3x3
// Gaussian blur stream block.
// ----------------------------------------------------------------------------
package gb3_pkg;

  localparam int PIX_W       = 8;
  localparam int CFG_WIDTH_W = 11;
  localparam int CFG_HEIGHT_W = 12;
  localparam int ROW_W       = 12;
  localparam int OUT_COL_W   = 10;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;

  // smallest frame dimension, and first row/column that has a full window
  localparam int MIN_DIM      = 3;
  localparam int MIN_INTERIOR = 2;

  // Q0.10 kernel weights
  localparam int FRAC_BITS = 10;
  localparam int W_EDGE    = 86;
  localparam int W_DIAG    = 65;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic                 interior;
    logic                 last;
    logic [OUT_COL_W-1:0] col;
    logic [ROW_W-1:0]     row;
  } pos_t;

endpackage

>>> src/gb3_ram.sv
// ----------------------------------------------------------------------------
// gb3_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gb3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/gb3_scan.sv
// ----------------------------------------------------------------------------
// gb3_scan
// Raster position counters: column and row of each accepted pixel, with
// width/height clamping and the interior / end-of-frame flags.
// ----------------------------------------------------------------------------
module gb3_scan #(
  parameter int MAX_LINE = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 step_i,
  input  logic [gb3_pkg::CFG_WIDTH_W-1:0]      width_i,
  input  logic [gb3_pkg::CFG_HEIGHT_W-1:0]     height_i,
  output logic [$clog2(MAX_LINE)-1:0]          addr_o,
  output gb3_pkg::pos_t                        pos_o
);

  localparam int CW  = $clog2(MAX_LINE);
  localparam int LW  = $clog2(MAX_LINE + 1);
  localparam int WW  = (LW > gb3_pkg::CFG_WIDTH_W) ? LW : gb3_pkg::CFG_WIDTH_W;
  localparam int RW  = gb3_pkg::ROW_W;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  logic [WW-1:0] w_raw, w_eff;
  logic [RW-1:0] h_eff;
  logic          wrap;
  logic [CW-1:0] c;
  logic [RW:0]   r_inc;
  logic [RW-1:0] r;
  logic          last_col, last_row;
  logic [RW:0]   r_p1;

  always_comb begin
    w_raw = WW'(width_i);
    priority if (w_raw < WW'(gb3_pkg::MIN_DIM)) begin
      w_eff = WW'(gb3_pkg::MIN_DIM);
    end else if (w_raw > WW'(MAX_LINE)) begin
      w_eff = WW'(MAX_LINE);
    end else begin
      w_eff = w_raw;
    end
    h_eff = (height_i < RW'(gb3_pkg::MIN_DIM)) ? RW'(gb3_pkg::MIN_DIM) : height_i;

    // a width lowered mid-frame ends the row early
    wrap  = (WW'(col_r) >= w_eff);
    c     = wrap ? '0 : col_r;
    r_inc = {1'b0, row_r} + (RW+1)'(wrap);
    r     = (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[RW-1:0];

    last_col = (WW'(c) == w_eff - WW'(1));
    last_row = (r == h_eff - RW'(1));
    r_p1     = {1'b0, r} + (RW+1)'(1);

    if (last_col) begin
      col_nxt = '0;
      row_nxt = (r_p1 >= {1'b0, h_eff}) ? '0 : r_p1[RW-1:0];
    end else begin
      col_nxt = c + CW'(1);
      row_nxt = r;
    end

    addr_o         = c;
    pos_o.interior = (r >= RW'(gb3_pkg::MIN_INTERIOR)) &&
                     (WW'(c) >= WW'(gb3_pkg::MIN_INTERIOR));
    pos_o.last     = last_row && last_col;
    pos_o.col      = gb3_pkg::OUT_COL_W'(c - CW'(1));
    pos_o.row      = r - RW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (step_i) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

>>> src/gb3_window.sv
// ----------------------------------------------------------------------------
// gb3_window
// 3x3 window register and the Q0.10 kernel applied to the shifted window.
// ----------------------------------------------------------------------------
module gb3_window (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     shift_i,
  input  logic [gb3_pkg::PIX_W-1:0] up2_i,
  input  logic [gb3_pkg::PIX_W-1:0] up1_i,
  input  logic [gb3_pkg::PIX_W-1:0] px_i,
  output logic [gb3_pkg::PIX_W-1:0] blur_o
);

  localparam int PW = gb3_pkg::PIX_W;
  localparam int FB = gb3_pkg::FRAC_BITS;

  // index 3*row + col: row 0 top, col 2 newest
  logic [PW-1:0] win_r   [9];
  logic [PW-1:0] win_nxt [9];

  logic [PW+1:0]  sum_v;
  logic [PW:0]    sum_h, sum_dl, sum_dr;
  logic [PW+8:0]  s0;
  logic [PW+7:0]  s1, s2, s3;
  logic [PW+1:0]  total;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_nxt[3*k]     = win_r[3*k+1];
      win_nxt[3*k + 1] = win_r[3*k+2];
    end
    win_nxt[2] = up2_i;
    win_nxt[5] = up1_i;
    win_nxt[8] = px_i;

    sum_v  = (PW+2)'(win_nxt[4]) + (PW+2)'(win_nxt[1]) + (PW+2)'(win_nxt[7]);
    sum_h  = (PW+1)'(win_nxt[3]) + (PW+1)'(win_nxt[5]);
    sum_dl = (PW+1)'(win_nxt[8]) + (PW+1)'(win_nxt[6]);
    sum_dr = (PW+1)'(win_nxt[2]) + (PW+1)'(win_nxt[0]);

    s0 = (PW+9)'(sum_v)  * (PW+9)'(gb3_pkg::W_EDGE);
    s1 = (PW+8)'(sum_h)  * (PW+8)'(gb3_pkg::W_EDGE);
    s2 = (PW+8)'(sum_dl) * (PW+8)'(gb3_pkg::W_DIAG);
    s3 = (PW+8)'(sum_dr) * (PW+8)'(gb3_pkg::W_DIAG);

    // truncate each partial sum on its own, peak total is 170
    total = (PW+2)'(s0 >> FB) + (PW+2)'(s1 >> FB) +
            (PW+2)'(s2 >> FB) + (PW+2)'(s3 >> FB);
    blur_o = total[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= '0;
      end
    end else if (shift_i) begin
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
  end

endmodule

>>> src/gaussian_blur_3x3_stream_top.sv
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_stream_top
// Streaming 3x3 Gaussian blur on 8-bit grey pixels in raster order; one
// blurred value per interior pixel, none for border pixels.
//
//   channel  direction  handshake             payload
//   in_      sink       in_valid / in_ready   in_pixel_in
//   out_     source     out_valid / out_ready out_blurred, out_col, out_row,
//                                             out_frame_last
//   APB      config     psel/penable/pready   reg 0 width @0x0, reg 1 height @0x4
//
// One pixel per clock sustained while out_ready is high. Line stores are
// read at acceptance; window shift and kernel go into the output register
// when the stage behind it advances. A stall on out_ready holds the output
// register and the stage behind it; in_ready drops only when both are full.
// Synchronous active-low reset clears counters, window and valid flags; the
// line stores are not cleared.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_stream_top #(
  parameter int MAX_LINE = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [gb3_pkg::PIX_W-1:0]           in_pixel_in,

  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [gb3_pkg::PIX_W-1:0]           out_blurred,
  output logic [gb3_pkg::OUT_COL_W-1:0]       out_col,
  output logic [gb3_pkg::ROW_W-1:0]           out_row,
  output logic                                out_frame_last,

  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gb3_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [gb3_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [gb3_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);

  localparam int CW = $clog2(MAX_LINE);
  localparam int PW = gb3_pkg::PIX_W;

  // configuration registers
  logic [gb3_pkg::CFG_WIDTH_W-1:0]  cfg_width_r;
  logic [gb3_pkg::CFG_HEIGHT_W-1:0] cfg_height_r;
  logic                             cfg_wr;
  gb3_pkg::reg_idx_t                cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = gb3_pkg::reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_idx)
      gb3_pkg::REG_WIDTH:  prdata = gb3_pkg::APB_DATA_W'(cfg_width_r);
      gb3_pkg::REG_HEIGHT: prdata = gb3_pkg::APB_DATA_W'(cfg_height_r);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= gb3_pkg::WIDTH_RESET;
      cfg_height_r <= gb3_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        gb3_pkg::REG_WIDTH:  cfg_width_r  <= pwdata[gb3_pkg::CFG_WIDTH_W-1:0];
        gb3_pkg::REG_HEIGHT: cfg_height_r <= pwdata[gb3_pkg::CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic          in_fire;
  logic          s1_valid_r;
  logic          s1_adv;
  gb3_pkg::pos_t s1_pos_r;
  logic [CW-1:0] s1_addr_r;
  logic [PW-1:0] s1_pix_r;

  logic [CW-1:0] scan_addr;
  gb3_pkg::pos_t scan_pos;
  logic [PW-1:0] rd_a, rd_b;
  logic [PW-1:0] blur;

  logic                          out_valid_r;
  logic [PW-1:0]                 out_blurred_r;
  logic [gb3_pkg::OUT_COL_W-1:0] out_col_r;
  logic [gb3_pkg::ROW_W-1:0]     out_row_r;
  logic                          out_last_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  gb3_scan #(
    .MAX_LINE (MAX_LINE)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_i   (in_fire),
    .width_i  (cfg_width_r),
    .height_i (cfg_height_r),
    .addr_o   (scan_addr),
    .pos_o    (scan_pos)
  );

  // row above: read on request, overwrite with the new pixel as it moves on
  gb3_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_LINE)
  ) u_line_a (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_addr_r),
    .wdata (s1_pix_r),
    .re    (in_fire),
    .raddr (scan_addr),
    .rdata (rd_a)
  );

  // two rows above: takes the old row-above value
  gb3_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_LINE)
  ) u_line_b (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_addr_r),
    .wdata (rd_a),
    .re    (in_fire),
    .raddr (scan_addr),
    .rdata (rd_b)
  );

  gb3_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .shift_i (s1_adv),
    .up2_i   (rd_b),
    .up1_i   (rd_a),
    .px_i    (s1_pix_r),
    .blur_o  (blur)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= s1_pos_r.interior;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pos_r  <= scan_pos;
      s1_addr_r <= scan_addr;
      s1_pix_r  <= in_pixel_in;
    end
    if (s1_adv && s1_pos_r.interior) begin
      out_blurred_r <= blur;
      out_col_r     <= s1_pos_r.col;
      out_row_r     <= s1_pos_r.row;
      out_last_r    <= s1_pos_r.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_blurred    = out_blurred_r;
  assign out_col        = out_col_r;
  assign out_row        = out_row_r;
  assign out_frame_last = out_last_r;

  // a result appears only when the stage behind the output register moves
  a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv))
    else $error("result raised without a stage advance");

  a_interior_emits: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_pos_r.interior |=> out_valid_r)
    else $error("interior pixel dropped");

  a_border_silent: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !s1_pos_r.interior |=> !out_valid_r)
    else $error("border pixel produced a result");

  a_last_interior: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_pos_r.last |-> s1_pos_r.interior)
    else $error("frame end flagged on a border pixel");

  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("request taken while both stages are held");

endmodule

>>> tb/sv/gaussian_blur_3x3_stream_top_tb.sv
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_stream_top_tb
// Self-checking bench for the streaming 3x3 Gaussian blur. A queue-fed driver
// offers pixels, a clocked monitor predicts each blurred interior pixel from
// its own line stores and window, and checks every result in order. Frame
// sizes, including out-of-range and mid-frame register writes, change
// between batches, and both channels idle at varying rates.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_stream_top_tb;

  localparam int CLK_PERIOD     = 4;
  localparam int MAX_LINE       = 1024;
  localparam int EDGE_WT        = 86;
  localparam int DIAG_WT        = 65;
  localparam int Q_SHIFT        = 10;
  localparam int WIDTH_AT_RESET = 640;
  localparam int HEIGHT_AT_RST  = 480;
  localparam int DRAIN_CYCLES   = 8;
  localparam int IDLE_LIMIT     = 50000;
  localparam int TIMEOUT_CYCLES = 600000;
  localparam int HOLD_CYCLES    = 150;
  localparam int PHASE_ITEMS    = 250;
  localparam int PRINT_LIMIT    = 40;

  localparam int PIX_W     = gb3_pkg::PIX_W;
  localparam int OUT_COL_W = gb3_pkg::OUT_COL_W;
  localparam int ROW_W     = gb3_pkg::ROW_W;
  localparam int CFG_W_W   = gb3_pkg::CFG_WIDTH_W;
  localparam int CFG_H_W   = gb3_pkg::CFG_HEIGHT_W;
  localparam int DATA_W    = gb3_pkg::APB_DATA_W;

  typedef struct {
    logic [PIX_W-1:0]     blurred;
    logic [OUT_COL_W-1:0] col;
    logic [ROW_W-1:0]     row;
    logic                 last;
  } blur_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [PIX_W-1:0]                in_pixel_in = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [PIX_W-1:0]                out_blurred;
  logic [OUT_COL_W-1:0]            out_col;
  logic [ROW_W-1:0]                out_row;
  logic                            out_frame_last;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [gb3_pkg::APB_ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]               pwdata = '0;
  logic [DATA_W-1:0]               prdata;
  logic                            pready;

  logic [PIX_W-1:0] pixel_q [$];
  blur_result_t     blur_q [$];

  // blur predictor state
  logic [PIX_W-1:0]   line_a [MAX_LINE] = '{default: '0};
  logic [PIX_W-1:0]   line_b [MAX_LINE] = '{default: '0};
  logic [PIX_W-1:0]   win [9] = '{default: '0};
  int                 touches [MAX_LINE];
  int                 col_pos = 0;
  int                 row_pos = 0;
  logic [CFG_W_W-1:0] cfg_width = WIDTH_AT_RESET;
  logic [CFG_H_W-1:0] cfg_height = HEIGHT_AT_RST;

  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   errors = 0;

  gaussian_blur_3x3_stream_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_in    (in_pixel_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_blurred    (out_blurred),
    .out_col        (out_col),
    .out_row        (out_row),
    .out_frame_last (out_frame_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic int eff_width(input int raw);
    if (raw < gb3_pkg::MIN_DIM) return gb3_pkg::MIN_DIM;
    if (raw > MAX_LINE) return MAX_LINE;
    return raw;
  endfunction

  function automatic int eff_height(input int raw);
    return (raw < gb3_pkg::MIN_DIM) ? gb3_pkg::MIN_DIM : raw;
  endfunction

  // position the next pixel lands on: wrap a finished row, restart a finished frame
  function automatic void upcoming_pos(input int w, input int h, output int c, output int r);
    c = col_pos;
    r = row_pos;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r >= h) r = 0;
  endfunction

  // a new width is allowed only if no interior pixel would read a line store
  // entry that has not been written twice by the time it is needed
  function automatic bit width_ok(input int w, input int h);
    int c, r, j, need;
    upcoming_pos(w, h, c, r);
    for (j = 0; j < w; j++) begin
      need = (j >= c) ? ((r > 2) ? 2 : r) : ((r == 0) ? 1 : 2);
      if (touches[j] < need) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  task automatic log_error(input string msg);
    errors++;
    if (errors <= PRINT_LIMIT) $display("ERROR: %s", msg);
  endtask

  task automatic check_field(input string name, input blur_result_t want,
                             input logic [ROW_W-1:0] exp_val, input logic [ROW_W-1:0] got);
    if (got !== exp_val)
      log_error($sformatf("%s at row %0d col %0d: expected %0d, got %0d",
                          name, want.row, want.col, exp_val, got));
  endtask

  task automatic predict_pixel(input logic [PIX_W-1:0] px);
    int w, h, c, r, k, s0, s1, s2, s3;
    logic [PIX_W-1:0] up1, up2;
    blur_result_t res;
    w = eff_width(int'(cfg_width));
    h = eff_height(int'(cfg_height));
    upcoming_pos(w, h, c, r);
    up2 = line_b[c];
    up1 = line_a[c];
    line_b[c] = up1;
    line_a[c] = px;
    if (touches[c] < 2) touches[c]++;
    for (k = 0; k < 3; k++) begin
      win[3*k]   = win[3*k+1];
      win[3*k+1] = win[3*k+2];
    end
    win[2] = up2;
    win[5] = up1;
    win[8] = px;
    if (r >= gb3_pkg::MIN_INTERIOR && c >= gb3_pkg::MIN_INTERIOR) begin
      s0 = EDGE_WT * (int'(win[4]) + int'(win[1]) + int'(win[7]));
      s1 = EDGE_WT * (int'(win[3]) + int'(win[5]));
      s2 = DIAG_WT * (int'(win[8]) + int'(win[6]));
      s3 = DIAG_WT * (int'(win[2]) + int'(win[0]));
      res.blurred = PIX_W'((s0 >> Q_SHIFT) + (s1 >> Q_SHIFT) + (s2 >> Q_SHIFT)
                           + (s3 >> Q_SHIFT));
      res.col  = OUT_COL_W'(c - 1);
      res.row  = ROW_W'(r - 1);
      res.last = (r == h - 1) && (c == w - 1);
      blur_q.push_back(res);
    end
    col_pos = c + 1;
    row_pos = r;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic cfg_write(input gb3_pkg::reg_idx_t idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == gb3_pkg::REG_WIDTH) cfg_width = value[CFG_W_W-1:0];
    else cfg_height = value[CFG_H_W-1:0];
  endtask

  // hold until every pixel is taken and every result seen, then let the pipe drain
  task automatic wait_idle();
    int spent;
    spent = 0;
    @(negedge clk);
    while ((pixel_q.size() != 0 || in_valid || blur_q.size() != 0) && spent < IDLE_LIMIT) begin
      @(negedge clk);
      spent++;
    end
    if (spent >= IDLE_LIMIT) begin
      log_error($sformatf("block did not go idle, %0d results outstanding", blur_q.size()));
      blur_q.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reconfigure();
    int w_raw, h_raw, tries;
    bit w_found;
    if ($urandom_range(9) < 7) begin
      case ($urandom_range(9))
        0: h_raw = $urandom_range(2);
        1: h_raw = $urandom_range(1) ? 4095 : $urandom_range(11, 4095);
        default: h_raw = $urandom_range(3, 10);
      endcase
      cfg_write(gb3_pkg::REG_HEIGHT, h_raw);
    end
    if ($urandom_range(9) < 7) begin
      w_found = 1'b0;
      for (tries = 0; tries < 8 && !w_found; tries++) begin
        case ($urandom_range(9))
          0: w_raw = $urandom_range(2);
          1: w_raw = $urandom_range(1) ? MAX_LINE : $urandom_range(MAX_LINE + 1, 2047);
          2: w_raw = 2047;
          default: w_raw = $urandom_range(3, 24);
        endcase
        w_found = width_ok(eff_width(w_raw), eff_height(int'(cfg_height)));
      end
      if (w_found) cfg_write(gb3_pkg::REG_WIDTH, w_raw);
    end
  endtask

  // pixel sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid    <= 1'b1;
        in_pixel_in <= pixel_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // one long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin : monitor
    blur_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (blur_q.size() == 0) begin
          log_error($sformatf("unexpected result at row %0d col %0d", out_row, out_col));
        end else begin
          want = blur_q.pop_front();
          check_field("blurred", want, ROW_W'(want.blurred), ROW_W'(out_blurred));
          check_field("out_col", want, ROW_W'(want.col), ROW_W'(out_col));
          check_field("out_row", want, want.row, out_row);
          check_field("frame_last", want, ROW_W'(want.last), ROW_W'(out_frame_last));
        end
      end
      if (in_valid && in_ready) predict_pixel(in_pixel_in);
    end
  end

  initial begin : stimulus
    int phase, fed, n, w, h, c, r, k;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // smallest frame, saturated pixels, then the same size reached by clamping
    cfg_write(gb3_pkg::REG_WIDTH, 3);
    cfg_write(gb3_pkg::REG_HEIGHT, 3);
    @(negedge clk);
    repeat (9) pixel_q.push_back('1);
    wait_idle();
    cfg_write(gb3_pkg::REG_WIDTH, 0);
    cfg_write(gb3_pkg::REG_HEIGHT, 2);
    @(negedge clk);
    for (k = 0; k < 9; k++) pixel_q.push_back({PIX_W{k[0]}});
    wait_idle();

    // stall the output long enough for the block to back up its input
    cfg_write(gb3_pkg::REG_WIDTH, 16);
    cfg_write(gb3_pkg::REG_HEIGHT, 8);
    @(negedge clk);
    hold_req = 1'b1;
    repeat (256) pixel_q.push_back(random_pixel());
    wait_idle();

    for (phase = 0; phase < 4; phase++) begin
      @(negedge clk);
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 83; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 83; end
        default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
      endcase
      fed = 0;
      while (fed < PHASE_ITEMS) begin
        reconfigure();
        w = eff_width(int'(cfg_width));
        h = eff_height(int'(cfg_height));
        upcoming_pos(w, h, c, r);
        // mostly finish the frame, sometimes stop part-way
        if (w * h <= 200 && $urandom_range(3) != 0)
          n = (h - r) * w - c + ($urandom_range(1) ? w * h : 0);
        else
          n = $urandom_range(1, 80);
        @(negedge clk);
        repeat (n) pixel_q.push_back(random_pixel());
        fed += n;
        wait_idle();
      end
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Test completed with failures");
    $finish;
  end

endmodule
